### hdl/carm_pkg.sv
package carm_pkg;

  localparam int RULE_SLOTS     = 4;
  localparam int STATE_COUNT    = 8;
  localparam int NEIGHBOR_COUNT = 8;

  // register layout is fixed by the config map
  localparam int BOUND_REGS     = 4;
  localparam int NEIGHBOR_PORTS = 8;
  localparam int STATE_W        = 3;
  localparam int BOUND_W        = 4;
  localparam int BOUNDS_W       = 64;
  localparam int CTL_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;

  localparam int LANES = (RULE_SLOTS < BOUND_REGS) ? RULE_SLOTS : BOUND_REGS;
  localparam int CNT_W = $clog2(NEIGHBOR_COUNT + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RULE_CONTROLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_COUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_STATE = 3'd6;

  // rule control byte fields
  localparam int CTL_DEST_LSB = 0;
  localparam int CTL_REQ_BIT  = 3;
  localparam int CTL_REQ_LSB  = 4;

  typedef logic [STATE_COUNT-1:0][CNT_W-1:0] count_vec_t;

  typedef struct packed {
    logic                valid;
    logic [STATE_W-1:0]  center;
    count_vec_t          counts;
  } stage_t;

endpackage

### hdl/carm_count.sv
module carm_count (
  input  logic                                                       clk_i,
  input  logic                                                       rst_ni,
  input  logic                                                       adv_i,
  input  logic                                                       in_valid_i,
  input  logic [carm_pkg::STATE_W-1:0]                               center_i,
  input  logic [carm_pkg::NEIGHBOR_PORTS-1:0]                        nb_valid_i,
  input  logic [carm_pkg::NEIGHBOR_PORTS-1:0][carm_pkg::STATE_W-1:0] nb_state_i,
  output carm_pkg::stage_t                                           stage_o
);
  import carm_pkg::*;

  count_vec_t counts_d;
  logic       valid_q;
  logic [STATE_W-1:0] center_q;
  count_vec_t counts_q;

  // one popcount per state bin
  always_comb begin
    logic [NEIGHBOR_COUNT-1:0] hit;
    for (int s = 0; s < STATE_COUNT; s++) begin
      for (int k = 0; k < NEIGHBOR_COUNT; k++) begin
        hit[k] = nb_valid_i[k] && (nb_state_i[k] == STATE_W'(s));
      end
      counts_d[s] = CNT_W'($countones(hit));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && in_valid_i) begin
      center_q <= center_i;
      counts_q <= counts_d;
    end
  end

  assign stage_o = '{valid: valid_q, center: center_q, counts: counts_q};

endmodule

### hdl/carm_lane.sv
module carm_lane (
  input  carm_pkg::stage_t               stage_i,
  input  logic [carm_pkg::BOUNDS_W-1:0]  bounds_i,
  input  logic [7:0]                     ctl_i,
  input  logic                           active_i,
  output logic                           match_o
);
  import carm_pkg::*;

  logic [STATE_COUNT-1:0] in_range;
  logic                   center_ok;

  always_comb begin
    for (int s = 0; s < STATE_COUNT; s++) begin
      in_range[s] = (BOUND_W'(stage_i.counts[s]) >= bounds_i[BOUND_W*s +: BOUND_W]) &&
                    (BOUND_W'(stage_i.counts[s]) <= bounds_i[BOUNDS_W/2 + BOUND_W*s +: BOUND_W]);
    end
  end

  assign center_ok = !ctl_i[CTL_REQ_BIT] ||
                     (ctl_i[CTL_REQ_LSB +: STATE_W] == stage_i.center);

  assign match_o = active_i && center_ok && (&in_range);

endmodule

### hdl/carm_merge.sv
module carm_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               s1_valid_i,
  input  logic [carm_pkg::LANES-1:0]         match_i,
  input  logic [carm_pkg::CTL_W-1:0]         ctl_i,
  input  logic [carm_pkg::STATE_W-1:0]       default_i,
  output logic                               out_valid_o,
  output logic [carm_pkg::STATE_W-1:0]       next_state_o,
  output logic                               used_default_o
);
  import carm_pkg::*;

  logic               valid_q;
  logic [STATE_W-1:0] state_d, state_q;
  logic               dflt_d, dflt_q;

  // lowest matching lane wins
  always_comb begin
    state_d = default_i;
    dflt_d  = 1'b1;
    for (int r = LANES - 1; r >= 0; r--) begin
      if (match_i[r]) begin
        state_d = ctl_i[8*r + CTL_DEST_LSB +: STATE_W];
        dflt_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s1_valid_i) begin
      state_q <= state_d;
      dflt_q  <= dflt_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign next_state_o   = state_q;
  assign used_default_o = dflt_q;

endmodule

### hdl/cellular_automaton_rule_match_unit.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | center_state, neighbor_valid, neighbor_0..7
// out     | output    | out_valid_o/out_stall_i | next_state, used_default
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// Two-stage pipeline: state histogram into stage 1, rule lanes plus priority
// merge into the output register. One item per cycle while the output is not
// stalled. Throughput is set by the output register: an item moves on whenever
// the next stage is empty or is being drained. A stalled output still lets one
// more item into stage 1. Reset clears valids and all config registers to zero.
module cellular_automaton_rule_match_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [carm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [carm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [carm_pkg::STATE_W-1:0]        center_state_i,
  input  logic [carm_pkg::NEIGHBOR_PORTS-1:0] neighbor_valid_i,
  input  logic [carm_pkg::STATE_W-1:0]        neighbor_0_i,
  input  logic [carm_pkg::STATE_W-1:0]        neighbor_1_i,
  input  logic [carm_pkg::STATE_W-1:0]        neighbor_2_i,
  input  logic [carm_pkg::STATE_W-1:0]        neighbor_3_i,
  input  logic [carm_pkg::STATE_W-1:0]        neighbor_4_i,
  input  logic [carm_pkg::STATE_W-1:0]        neighbor_5_i,
  input  logic [carm_pkg::STATE_W-1:0]        neighbor_6_i,
  input  logic [carm_pkg::STATE_W-1:0]        neighbor_7_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [carm_pkg::STATE_W-1:0]        next_state_o,
  output logic                                used_default_o
);
  import carm_pkg::*;

  // config registers
  logic [BOUND_REGS-1:0][BOUNDS_W-1:0] bounds_q;
  logic [CTL_W-1:0]                    ctl_q;
  logic [STATE_W-1:0]                  rule_count_q;
  logic [STATE_W-1:0]                  default_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q     <= '0;
      ctl_q        <= '0;
      rule_count_q <= '0;
      default_q    <= '0;
    end else if (cfg_we_i) begin
      for (int b = 0; b < BOUND_REGS; b++) begin
        if (cfg_idx_i == CFG_IDX_W'(b)) begin
          bounds_q[b] <= cfg_wdata_i[BOUNDS_W-1:0];
        end
      end
      if (cfg_idx_i == REG_RULE_CONTROLS) begin
        ctl_q <= cfg_wdata_i[CTL_W-1:0];
      end
      if (cfg_idx_i == REG_RULE_COUNT) begin
        rule_count_q <= cfg_wdata_i[STATE_W-1:0];
      end
      if (cfg_idx_i == REG_DEFAULT_STATE) begin
        default_q <= cfg_wdata_i[STATE_W-1:0];
      end
      // indexes past the list fall through untouched
    end
  end

  // pipeline advance: a stage loads when the one after it has room
  logic   adv_out, adv_s1;
  stage_t s1;

  assign adv_out    = !out_valid_o || !out_stall_i;
  assign adv_s1     = !s1.valid || adv_out;
  assign in_stall_o = !adv_s1;

  logic [NEIGHBOR_PORTS-1:0][STATE_W-1:0] nb_state;
  assign nb_state = {neighbor_7_i, neighbor_6_i, neighbor_5_i, neighbor_4_i,
                     neighbor_3_i, neighbor_2_i, neighbor_1_i, neighbor_0_i};

  carm_count u_count (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv_s1),
    .in_valid_i (in_valid_i),
    .center_i   (center_state_i),
    .nb_valid_i (neighbor_valid_i),
    .nb_state_i (nb_state),
    .stage_o    (s1)
  );

  // one lane per rule slot, all test the same histogram
  logic [LANES-1:0] match;

  for (genvar r = 0; r < LANES; r++) begin : g_lane
    carm_lane u_lane (
      .stage_i  (s1),
      .bounds_i (bounds_q[r]),
      .ctl_i    (ctl_q[8*r +: 8]),
      .active_i (int'(rule_count_q) > r),
      .match_o  (match[r])
    );
  end

  carm_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv_out),
    .s1_valid_i     (s1.valid),
    .match_i        (match),
    .ctl_i          (ctl_q),
    .default_i      (default_q),
    .out_valid_o    (out_valid_o),
    .next_state_o   (next_state_o),
    .used_default_o (used_default_o)
  );

  // stall only when stage 1 holds an item it cannot pass on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1.valid && out_valid_o && out_stall_i))
    else $error("input stalled with room in the pipe");

  // a held item in stage 1 is not dropped while the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1.valid && out_valid_o && out_stall_i) |=> s1.valid)
    else $error("stage 1 item lost under stall");

  // a new result only comes from an item that sat in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1.valid))
    else $error("result without a source item");

  // a blocked result stays in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(next_state_o)
                                      && $stable(used_default_o)))
    else $error("blocked result changed");

endmodule

### tb/sv/tb_cellular_automaton_rule_match_unit.sv
// Cell-update rule matcher testbench.
// A scoreboard model counts the present neighbors per state, walks the active
// rules in priority order and queues the next state it expects for every item
// taken by the block. Each result leaving the block is checked against the
// oldest queued entry. The run starts with directed checks: reset values, rule
// priority, rule count saturation, the unused register index, field and
// register extremes. Random traffic follows, under a new random rule set for
// each phase. A final phase holds the output off long enough to back up the
// pipeline into the input.
module tb_cellular_automaton_rule_match_unit;
  import carm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_0 = 3'd0;
  // no register behind this index, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;

  // lo = 0 and hi = 15 for every state: passes any histogram
  localparam logic [BOUNDS_W-1:0] OPEN_BOUNDS = 64'hFFFF_FFFF_0000_0000;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 11;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 105;

  typedef struct packed {
    logic [STATE_W-1:0]                          center;
    logic [NEIGHBOR_PORTS-1:0]                   present;
    logic [NEIGHBOR_PORTS-1:0][STATE_W-1:0]      nbr;
  } cell_t;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic               dflt;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                                   in_valid = 1'b0;
  logic                                   in_stall;
  logic [STATE_W-1:0]                     in_center = '0;
  logic [NEIGHBOR_PORTS-1:0]              in_present = '0;
  logic [NEIGHBOR_PORTS-1:0][STATE_W-1:0] in_nbr = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STATE_W-1:0] next_state;
  logic               used_default;

  // shadow copy of the rule registers, updated on every write strobe
  logic [BOUND_REGS-1:0][BOUNDS_W-1:0] bounds_sh = '0;
  logic [CTL_W-1:0]                    controls_sh = '0;
  logic [2:0]                          rule_count_sh = '0;
  logic [STATE_W-1:0]                  default_sh = '0;

  verdict_t next_state_q[$];
  int       errors = 0;
  int       idle_cycles = 0;

  // traffic shaping knobs, set by the test tasks
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold = 0;

  wire in_take  = in_valid && !in_stall;
  wire out_take = out_valid && !out_stall;

  always #1 clk = ~clk;

  cellular_automaton_rule_match_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .center_state_i (in_center),
    .neighbor_valid_i(in_present),
    .neighbor_0_i   (in_nbr[0]),
    .neighbor_1_i   (in_nbr[1]),
    .neighbor_2_i   (in_nbr[2]),
    .neighbor_3_i   (in_nbr[3]),
    .neighbor_4_i   (in_nbr[4]),
    .neighbor_5_i   (in_nbr[5]),
    .neighbor_6_i   (in_nbr[6]),
    .neighbor_7_i   (in_nbr[7]),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .next_state_o   (next_state),
    .used_default_o (used_default)
  );

  // ---------------------------------------------------------------------------
  // Scoreboard model
  // ---------------------------------------------------------------------------

  // Histogram of present neighbors, then first rule whose per-state window
  // holds every count (and whose center requirement, if any, is met).
  function automatic verdict_t predict_next_state(cell_t c);
    int          tally [STATE_COUNT];
    int          lanes;
    logic [7:0]  ctl;
    logic [63:0] b;
    logic        fits;
    verdict_t    v;
    for (int s = 0; s < STATE_COUNT; s++) tally[s] = 0;
    // neighbors past NEIGHBOR_COUNT and states past STATE_COUNT drop out
    for (int k = 0; k < NEIGHBOR_COUNT; k++) begin
      if (c.present[k] && c.nbr[k] < STATE_COUNT) tally[c.nbr[k]]++;
    end
    // rule count saturates at the slot count and the bounds register count
    lanes = rule_count_sh;
    if (lanes > RULE_SLOTS) lanes = RULE_SLOTS;
    if (lanes > BOUND_REGS) lanes = BOUND_REGS;
    v.state = default_sh;
    v.dflt  = 1'b1;
    for (int r = 0; r < lanes && v.dflt; r++) begin
      ctl  = controls_sh[8*r +: 8];
      b    = bounds_sh[r];
      fits = !(ctl[CTL_REQ_BIT] && ctl[CTL_REQ_LSB +: STATE_W] != c.center);
      // min above max simply never passes here
      for (int s = 0; s < STATE_COUNT; s++) begin
        if (tally[s] < b[BOUND_W*s +: BOUND_W] || tally[s] > b[32 + BOUND_W*s +: BOUND_W])
          fits = 1'b0;
      end
      if (fits) begin
        v.state = ctl[CTL_DEST_LSB +: STATE_W];
        v.dflt  = 1'b0;
      end
    end
    return v;
  endfunction

  // Shadow registers follow the write port; unknown indexes are dropped.
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      if (cfg_idx < BOUND_REGS) bounds_sh[cfg_idx] <= cfg_wdata;
      else if (cfg_idx == REG_RULE_CONTROLS) controls_sh <= cfg_wdata[CTL_W-1:0];
      else if (cfg_idx == REG_RULE_COUNT) rule_count_sh <= cfg_wdata[2:0];
      else if (cfg_idx == REG_DEFAULT_STATE) default_sh <= cfg_wdata[STATE_W-1:0];
    end
  end

  // Every item taken by the block queues one expected next state. Inputs are
  // read before this edge's updates land, i.e. the values the block saw.
  always @(posedge clk) begin
    cell_t c;
    if (rst_n && in_take) begin
      c.center  = in_center;
      c.present = in_present;
      c.nbr     = in_nbr;
      next_state_q = {next_state_q, predict_next_state(c)};
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_take) begin
      if (next_state_q.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0b with nothing pending",
                                  next_state, used_default));
      end else begin
        exp_v = next_state_q.pop_front();
        if (next_state !== exp_v.state)
          report_mismatch($sformatf("next_state %0d, want %0d", next_state, exp_v.state));
        if (used_default !== exp_v.dflt)
          report_mismatch($sformatf("used_default %0b, want %0b", used_default, exp_v.dflt));
      end
    end
  end

  // Watchdog: too long without any handshake on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_take || out_take) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall before each result, or one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (rx_hold > 0) n = rx_hold;
      else n = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      rx_hold = 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Item source and register access
  // ---------------------------------------------------------------------------

  // Optional gap, then offer the item and hold it until taken. valid stays up
  // across back-to-back items so there is one assignment per edge.
  task automatic send_cell(input cell_t c);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_center  <= c.center;
    in_present <= c.present;
    in_nbr     <= c.nbr;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and let every queued result drain; the pipeline is two deep
  // and each item leaves exactly one result, so a short tail is enough.
  // Waiting on the clock first makes sure the item taken at this edge is queued.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (next_state_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_rules(input logic [BOUND_REGS-1:0][BOUNDS_W-1:0] bounds,
                            input logic [CTL_W-1:0] controls,
                            input logic [2:0] count,
                            input logic [STATE_W-1:0] dflt);
    for (int r = 0; r < BOUND_REGS; r++)
      set_reg(REG_BOUNDS_0 + CFG_IDX_W'(r), bounds[r]);
    set_reg(REG_RULE_CONTROLS, CFG_DATA_W'(controls));
    set_reg(REG_RULE_COUNT, CFG_DATA_W'(count));
    set_reg(REG_DEFAULT_STATE, CFG_DATA_W'(dflt));
  endtask

  function automatic logic [BOUNDS_W-1:0] set_window(input logic [BOUNDS_W-1:0] b,
                                                     input int s,
                                                     input logic [BOUND_W-1:0] lo,
                                                     input logic [BOUND_W-1:0] hi);
    b[BOUND_W*s +: BOUND_W]      = lo;
    b[32 + BOUND_W*s +: BOUND_W] = hi;
    return b;
  endfunction

  function automatic logic [7:0] ctl_byte(input logic [STATE_W-1:0] dest, input logic req,
                                          input logic [STATE_W-1:0] req_state);
    logic [7:0] c;
    c = '0;
    c[CTL_DEST_LSB +: STATE_W] = dest;
    c[CTL_REQ_BIT]             = req;
    c[CTL_REQ_LSB +: STATE_W]  = req_state;
    return c;
  endfunction

  function automatic cell_t mk_cell(input logic [STATE_W-1:0] center,
                                    input logic [NEIGHBOR_PORTS-1:0] present,
                                    input logic [NEIGHBOR_PORTS-1:0][STATE_W-1:0] nbr);
    cell_t c;
    c.center  = center;
    c.present = present;
    c.nbr     = nbr;
    return c;
  endfunction

  // Windows are mostly wide so rules do match; some are tight, a few raw
  // (which includes min above max).
  function automatic logic [BOUNDS_W-1:0] rand_bounds();
    logic [BOUNDS_W-1:0] b;
    logic [BOUND_W-1:0]  lo;
    logic [BOUND_W-1:0]  hi;
    b = OPEN_BOUNDS;
    for (int s = 0; s < STATE_COUNT; s++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          lo = 4'd0;
          hi = BOUND_W'($urandom_range(8, 15));
        end
        6, 7, 8: begin
          lo = BOUND_W'($urandom_range(0, 2));
          hi = lo + BOUND_W'($urandom_range(0, 3));
        end
        default: begin
          lo = BOUND_W'($urandom_range(0, 15));
          hi = BOUND_W'($urandom_range(0, 15));
        end
      endcase
      b = set_window(b, s, lo, hi);
    end
    return b;
  endfunction

  // Neighbor states come from a random palette 0..lim so counts pile up.
  function automatic cell_t rand_cell();
    cell_t c;
    int    lim;
    lim      = $urandom_range(0, 7);
    c.center = STATE_W'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0:       c.present = 8'hFF;
      1:       c.present = 8'h00;
      default: c.present = NEIGHBOR_PORTS'($urandom_range(0, 255));
    endcase
    for (int k = 0; k < NEIGHBOR_PORTS; k++)
      c.nbr[k] = STATE_W'($urandom_range(0, lim));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers reset to zero: no active rules, default state 0.
  task automatic test_after_reset();
    send_cell(mk_cell(3'd0, 8'h00, '0));
    send_cell(mk_cell(3'd7, 8'hFF, {8{3'd7}}));
  endtask

  // Rule 0 can never match (min above max), rule 1 needs center 5, rule 2
  // needs exactly three neighbors in state 3, rule 3 takes anything.
  task automatic test_rule_priority();
    logic [BOUND_REGS-1:0][BOUNDS_W-1:0] b;
    wait_idle();
    b[0] = set_window(OPEN_BOUNDS, 0, 4'hF, 4'h0);
    b[1] = OPEN_BOUNDS;
    b[2] = set_window(OPEN_BOUNDS, 3, 4'd3, 4'd3);
    b[3] = OPEN_BOUNDS;
    load_rules(b, {ctl_byte(3'd4, 1'b0, 3'd0), ctl_byte(3'd3, 1'b0, 3'd0),
                   ctl_byte(3'd2, 1'b1, 3'd5), ctl_byte(3'd1, 1'b0, 3'd0)},
               3'd4, 3'd6);
    send_cell(mk_cell(3'd5, 8'hFF, {15'd0, {3{3'd3}}}));
    send_cell(mk_cell(3'd0, 8'hFF, {15'd0, {3{3'd3}}}));
    send_cell(mk_cell(3'd0, 8'h03, {15'd0, {3{3'd3}}}));
    send_cell(mk_cell(3'd7, 8'h00, '0));
  endtask

  // Count above the slot count acts as four; smaller counts hide the tail.
  task automatic test_rule_count_saturation();
    wait_idle();
    set_reg(REG_RULE_COUNT, CFG_DATA_W'(7));
    send_cell(mk_cell(3'd0, 8'hFF, '0));
    wait_idle();
    set_reg(REG_RULE_COUNT, CFG_DATA_W'(2));
    send_cell(mk_cell(3'd5, 8'hF0, {8{3'd2}}));
    send_cell(mk_cell(3'd0, 8'hFF, {15'd0, {3{3'd3}}}));
    wait_idle();
    set_reg(REG_RULE_COUNT, CFG_DATA_W'(0));
    send_cell(mk_cell(3'd5, 8'hFF, '0));
  endtask

  // A write to the unused index must leave every rule register alone.
  task automatic test_unused_index();
    wait_idle();
    set_reg(REG_UNUSED, '1);
    send_cell(mk_cell(3'd5, 8'hFF, {15'd0, {3{3'd3}}}));
  endtask

  // Full neighborhood in one state: count of eight hits an 8..8 window.
  task automatic test_field_extremes();
    logic [BOUND_REGS-1:0][BOUNDS_W-1:0] b;
    wait_idle();
    b    = {BOUND_REGS{OPEN_BOUNDS}};
    b[0] = set_window(OPEN_BOUNDS, 7, 4'd8, 4'd8);
    load_rules(b, {24'd0, ctl_byte(3'd7, 1'b0, 3'd0)}, 3'd1, 3'd0);
    send_cell(mk_cell(3'd7, 8'hFF, {8{3'd7}}));
    send_cell(mk_cell(3'd0, 8'h7F, {8{3'd7}}));
    send_cell(mk_cell(3'd0, 8'hFF, {8{3'd0}}));
    send_cell(mk_cell(3'd3, 8'h80, {8{3'd7}}));
  endtask

  // All-ones registers: every window is 15..15, so nothing can match.
  // All-zero bounds: only an empty neighborhood passes.
  task automatic test_register_extremes();
    wait_idle();
    load_rules('1, '1, 3'd7, 3'd7);
    send_cell(mk_cell(3'd7, 8'hFF, {8{3'd7}}));
    wait_idle();
    load_rules('0, '0, 3'd1, 3'd5);
    send_cell(mk_cell(3'd0, 8'h00, {8{3'd7}}));
    send_cell(mk_cell(3'd0, 8'h01, '0));
  endtask

  // Random rule sets; phases rotate between random gaps on both sides,
  // a gapless sender and a sink that never stalls.
  task automatic test_random_traffic();
    logic [BOUND_REGS-1:0][BOUNDS_W-1:0] b;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 3 == 2);
      for (int r = 0; r < BOUND_REGS; r++) b[r] = rand_bounds();
      load_rules(b, $urandom, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      for (int i = 0; i < PHASE_ITEMS; i++) send_cell(rand_cell());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Sink holds off for a long stretch while items keep coming back to back;
  // the pipeline fills and in_stall_o has to push back.
  task automatic test_output_backpressure();
    wait_idle();
    tx_steady = 1'b1;
    rx_hold   = 150;
    for (int i = 0; i < 40; i++) send_cell(rand_cell());
    tx_steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_rule_priority();
    test_rule_count_saturation();
    test_unused_index();
    test_field_extremes();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();
    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
